FILE: hw/rtl/tcce_pkg.sv
// shared constants, codes and structs of the text console character engine
// no dependencies; every other file takes names from here by scope
`default_nettype none

package tcce_pkg;

   // screen geometry
   localparam int COLUMNS    = 80;
   localparam int LINES      = 24;
   localparam int TAB_STOP   = 8;
   localparam int CELL_COUNT = COLUMNS * LINES;
   localparam int CELL_AW    = $clog2(CELL_COUNT);

   // field widths
   localparam int CMD_W  = 2;
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;
   localparam int CELL_W = CHAR_W + ATTR_W;
   localparam int IDX_W  = 11;
   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int POS_W  = 11;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;
   localparam logic [CSR_IDX_W-1:0] REG_BLINK_ENABLE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BACKGROUND_COLOR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FOREGROUND_COLOR = 2'd2;

   // commands
   localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   // control bytes
   localparam logic [CHAR_W-1:0] CH_BELL      = 8'h07;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_VTAB      = 8'h0B;
   localparam logic [CHAR_W-1:0] CH_FORMFEED  = 8'h0C;
   localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
   localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h00;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [CHAR_W-1:0] character;
      logic [IDX_W-1:0]  cell_index;
   } item_type;

   typedef struct packed {
      logic [COL_W-1:0]  cursor_column;
      logic [ROW_W-1:0]  cursor_row;
      logic [POS_W-1:0]  cursor_position;
      logic              bell;
      logic [CHAR_W-1:0] cell_character;
      logic [ATTR_W-1:0] cell_attribute;
   } result_type;

   typedef struct packed {
      logic               wr_en;
      logic [CELL_AW-1:0] wr_addr;
      logic [CELL_W-1:0]  wr_data;
      logic               rd_en;
      logic [CELL_AW-1:0] rd_addr;
   } ram_req_type;

endpackage

`default_nettype wire

FILE: hw/rtl/tcce_intf.sv
// valid/ready channel interfaces: request, response and configuration write
// depends on tcce_pkg for field widths
`default_nettype none

interface tcce_req_if;
   logic                          valid;
   logic                          ready;
   logic [tcce_pkg::CMD_W-1:0]    command;
   logic [tcce_pkg::CHAR_W-1:0]   character;
   logic [tcce_pkg::IDX_W-1:0]    cell_index;

   modport source (output valid, command, character, cell_index, input ready);
   modport sink   (input valid, command, character, cell_index, output ready);
endinterface

interface tcce_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tcce_pkg::COL_W-1:0]    cursor_column;
   logic [tcce_pkg::ROW_W-1:0]    cursor_row;
   logic [tcce_pkg::POS_W-1:0]    cursor_position;
   logic                          bell;
   logic [tcce_pkg::CHAR_W-1:0]   cell_character;
   logic [tcce_pkg::ATTR_W-1:0]   cell_attribute;

   modport source (output valid, cursor_column, cursor_row, cursor_position, bell,
                   cell_character, cell_attribute, input ready);
   modport sink   (input valid, cursor_column, cursor_row, cursor_position, bell,
                   cell_character, cell_attribute, output ready);
endinterface

interface tcce_csr_if;
   logic                             valid;
   logic                             ready;
   logic [tcce_pkg::CSR_IDX_W-1:0]   index;
   logic [tcce_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/tcce_screen_ram.sv
// screen store: one write port, one read port with registered read data
// depends on tcce_pkg for depth, widths and the request struct
`default_nettype none

module tcce_screen_ram (
   input  wire logic                          clock,
   input  wire tcce_pkg::ram_req_type         ram_req,
   output logic [tcce_pkg::CELL_W-1:0]        rd_data
);

   logic [tcce_pkg::CELL_W-1:0] mem [tcce_pkg::CELL_COUNT];
   logic [tcce_pkg::CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/tcce_engine.sv
// command sequencer: cursor, control byte decode, scroll/clear sweep, cell read
// depends on tcce_pkg; drives the ports of tcce_screen_ram
`default_nettype none

module tcce_engine (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire tcce_pkg::item_type            item,
   input  wire logic [tcce_pkg::ATTR_W-1:0]   attr,
   input  wire logic                          out_free,
   output logic                               idle,
   output logic                               done,
   output tcce_pkg::result_type               result,
   output tcce_pkg::ram_req_type              ram_req,
   input  wire logic [tcce_pkg::CELL_W-1:0]   ram_rd_data
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_PUT    = 7'b0000010,
      ST_SWEEP  = 7'b0000100,
      ST_DRAIN  = 7'b0001000,
      ST_READ   = 7'b0010000,
      ST_FETCH  = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   localparam int CW = tcce_pkg::COL_W + 1;
   localparam logic [tcce_pkg::CELL_AW-1:0] LAST_CELL   = tcce_pkg::CELL_AW'(tcce_pkg::CELL_COUNT - 1);
   localparam logic [tcce_pkg::CELL_AW-1:0] LAST_ROW_AT =
      tcce_pkg::CELL_AW'(tcce_pkg::CELL_COUNT - tcce_pkg::COLUMNS);
   localparam logic [CW-1:0] TAB_MASK = CW'(tcce_pkg::TAB_STOP - 1);

   state_type                         state_ff, state_in;
   tcce_pkg::item_type                item_ff, item_in;
   logic [tcce_pkg::COL_W-1:0]        col_ff, col_in;
   logic [tcce_pkg::ROW_W-1:0]        row_ff, row_in;
   logic                              bell_ff, bell_in;
   logic [tcce_pkg::CELL_W-1:0]       cell_ff, cell_in;
   logic [tcce_pkg::CELL_AW-1:0]      scan_ff, scan_in;
   logic                              clear_ff, clear_in;
   logic                              pend_ff, pend_in;
   logic [tcce_pkg::CELL_AW-1:0]      pend_addr_ff, pend_addr_in;
   logic                              pend_blank_ff, pend_blank_in;

   logic [CW-1:0]                     col_next;
   logic [CW-1:0]                     tab_base;
   logic                              new_line;
   logic                              line_down;
   logic [tcce_pkg::CELL_AW-1:0]      cursor_addr;

   assign cursor_addr = tcce_pkg::CELL_AW'(row_ff) * tcce_pkg::CELL_AW'(tcce_pkg::COLUMNS)
                      + tcce_pkg::CELL_AW'(col_ff);

   assign tab_base = (((CW'(col_ff) + CW'(1)) & TAB_MASK) == '0) ? CW'(col_ff) + CW'(1)
                                                                 : CW'(col_ff);

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      bell_in       = bell_ff;
      cell_in       = cell_ff;
      scan_in       = scan_ff;
      clear_in      = clear_ff;
      pend_in       = 1'b0;
      pend_addr_in  = pend_addr_ff;
      pend_blank_in = pend_blank_ff;
      col_next      = CW'(col_ff);
      new_line      = 1'b0;
      line_down     = 1'b0;
      idle          = 1'b0;
      done          = 1'b0;
      ram_req.rd_en   = 1'b0;
      ram_req.rd_addr = scan_ff;
      ram_req.wr_en   = 1'b0;
      ram_req.wr_addr = pend_addr_ff;
      ram_req.wr_data = pend_blank_ff ? {attr, tcce_pkg::BLANK_CHAR} : ram_rd_data;

      // trailing write of the sweep pipeline
      if (pend_ff) begin
         ram_req.wr_en = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            idle = 1'b1;
            if (start) begin
               item_in = item;
               bell_in = 1'b0;
               cell_in = '0;
               unique case (item.command)
                  tcce_pkg::CMD_PUT: begin
                     state_in = ST_PUT;
                  end
                  tcce_pkg::CMD_CLEAR: begin
                     state_in = ST_SWEEP;
                     scan_in  = '0;
                     clear_in = 1'b1;
                     col_in   = '0;
                     row_in   = '0;
                  end
                  tcce_pkg::CMD_READ: begin
                     state_in = ST_READ;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_PUT: begin
            state_in = ST_FINISH;
            unique case (item_ff.character)
               tcce_pkg::CH_BELL: begin
                  bell_in = 1'b1;
               end
               tcce_pkg::CH_BACKSPACE: begin
                  if (col_ff != '0) begin
                     col_next = CW'(col_ff) - CW'(1);
                  end
               end
               tcce_pkg::CH_TAB: begin
                  col_next = (tab_base & ~TAB_MASK) + CW'(tcce_pkg::TAB_STOP);
                  new_line = (col_next >= CW'(tcce_pkg::COLUMNS));
               end
               tcce_pkg::CH_NEWLINE: begin
                  new_line = 1'b1;
               end
               tcce_pkg::CH_VTAB, tcce_pkg::CH_FORMFEED: begin
                  line_down = 1'b1;
               end
               tcce_pkg::CH_RETURN: begin
                  col_next = '0;
               end
               default: begin
                  ram_req.wr_en   = 1'b1;
                  ram_req.wr_addr = cursor_addr;
                  ram_req.wr_data = {attr, item_ff.character};
                  col_next        = CW'(col_ff) + CW'(1);
                  new_line        = (col_next >= CW'(tcce_pkg::COLUMNS));
               end
            endcase
            if (new_line) begin
               col_next  = '0;
               line_down = 1'b1;
            end
            col_in = col_next[tcce_pkg::COL_W-1:0];
            if (line_down) begin
               if (row_ff == tcce_pkg::ROW_W'(tcce_pkg::LINES - 1)) begin
                  state_in = ST_SWEEP;
                  scan_in  = '0;
                  clear_in = 1'b0;
               end else begin
                  row_in = row_ff + tcce_pkg::ROW_W'(1);
               end
            end
         end
         ST_SWEEP: begin
            // read one row below and write the held cell in the next cycle: the write address
            // always trails the read address, so the two never meet
            ram_req.rd_en   = !clear_ff && (scan_ff < LAST_ROW_AT);
            ram_req.rd_addr = scan_ff + tcce_pkg::CELL_AW'(tcce_pkg::COLUMNS);
            pend_in       = 1'b1;
            pend_addr_in  = scan_ff;
            pend_blank_in = clear_ff || (scan_ff >= LAST_ROW_AT);
            if (scan_ff == LAST_CELL) begin
               state_in = ST_DRAIN;
            end else begin
               scan_in = scan_ff + tcce_pkg::CELL_AW'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_READ: begin
            ram_req.rd_en   = (item_ff.cell_index < tcce_pkg::IDX_W'(tcce_pkg::CELL_COUNT));
            ram_req.rd_addr = item_ff.cell_index[tcce_pkg::CELL_AW-1:0];
            state_in        = ST_FETCH;
         end
         ST_FETCH: begin
            if (item_ff.cell_index < tcce_pkg::IDX_W'(tcce_pkg::CELL_COUNT)) begin
               cell_in = ram_rd_data;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         pend_ff  <= 1'b0;
         clear_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         pend_ff  <= pend_in;
         clear_ff <= clear_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      bell_ff       <= bell_in;
      cell_ff       <= cell_in;
      scan_ff       <= scan_in;
      pend_addr_ff  <= pend_addr_in;
      pend_blank_ff <= pend_blank_in;
   end

   assign result.cursor_column   = col_ff;
   assign result.cursor_row      = row_ff;
   assign result.cursor_position = tcce_pkg::POS_W'(cursor_addr);
   assign result.bell            = bell_ff;
   assign result.cell_character  = cell_ff[tcce_pkg::CHAR_W-1:0];
   assign result.cell_attribute  = cell_ff[tcce_pkg::CELL_W-1:tcce_pkg::CHAR_W];

`ifndef SYNTHESIS
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      col_ff < tcce_pkg::COL_W'(tcce_pkg::COLUMNS) && row_ff < tcce_pkg::ROW_W'(tcce_pkg::LINES))
      else $error("cursor left the screen");

   a_pend_from_sweep: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $past(state_ff) == ST_SWEEP)
      else $error("sweep write without a preceding sweep step");

   a_no_same_entry: assert property (@(posedge clock) disable iff (reset)
      ram_req.wr_en && ram_req.rd_en |-> ram_req.wr_addr != ram_req.rd_addr)
      else $error("read and write of the same cell in one cycle");

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      done |=> state_ff == ST_IDLE)
      else $error("sequencer did not return to idle after a result");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/text_console_character_engine_unit.sv
// top level of the text console character engine: channels, attribute registers, result register
// depends on tcce_pkg, tcce_intf, tcce_screen_ram and tcce_engine
//
// Character-cell text console of 80 columns by 24 rows. Each request transaction carries one
// command: put character (control bytes move the cursor, bell is flagged, any other byte is
// written with the current attribute and the cursor advances, wrapping and scrolling), clear
// screen, or read one cell. Each request gives exactly one response transaction with the cursor
// after the command and, for a read, the stored character and attribute. The screen lives in
// one single-port-write, one-port-read memory with a registered read, and the block works on one
// request at a time. A read waits for the memory's registered read data before the response is
// offered. The scroll and clear sweeps step through all 1920 cells, one cell write per cycle
// through the memory's write port, with the row copy streamed one read ahead. The memory needs
// no clearing after reset: reading a cell before anything was written there returns unspecified
// data. The attribute is blink<<7 | background<<4 | foreground and may only be changed while no
// request is in flight; configuration writes are always accepted.
`default_nettype none

module text_console_character_engine_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   tcce_req_if.sink   req_if,
   tcce_rsp_if.source rsp_if,
   tcce_csr_if.sink   csr_if
);

   // attribute registers
   logic                        blink_ff;
   logic [2:0]                  background_ff;
   logic [3:0]                  foreground_ff;
   logic [tcce_pkg::ATTR_W-1:0] attr;

   // response register, parts the engine from a stalled consumer
   logic                        rsp_valid_ff;
   tcce_pkg::result_type        rsp_ff;

   // engine hook-up
   tcce_pkg::item_type          item;
   tcce_pkg::result_type        result;
   tcce_pkg::ram_req_type       ram_req;
   logic [tcce_pkg::CELL_W-1:0] ram_rd_data;
   logic                        idle;
   logic                        done;
   logic                        out_free;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         blink_ff      <= 1'b0;
         background_ff <= '0;
         foreground_ff <= '0;
      end else if (csr_if.valid) begin
         // indexes past the register list are dropped
         if (csr_if.index == tcce_pkg::REG_BLINK_ENABLE) begin
            blink_ff <= csr_if.data[0];
         end
         if (csr_if.index == tcce_pkg::REG_BACKGROUND_COLOR) begin
            background_ff <= csr_if.data[2:0];
         end
         if (csr_if.index == tcce_pkg::REG_FOREGROUND_COLOR) begin
            foreground_ff <= csr_if.data[3:0];
         end
      end
   end

   assign attr = {blink_ff, background_ff, foreground_ff};

   // request side: a new transaction is taken whenever the sequencer is idle
   assign req_if.ready    = idle;
   assign item.command    = req_if.command;
   assign item.character  = req_if.character;
   assign item.cell_index = req_if.cell_index;

   // the engine may hand over a result when the response register is empty or draining
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   tcce_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .start       (req_if.valid),
      .item        (item),
      .attr        (attr),
      .out_free    (out_free),
      .idle        (idle),
      .done        (done),
      .result      (result),
      .ram_req     (ram_req),
      .ram_rd_data (ram_rd_data)
   );

   tcce_screen_ram u_screen_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_ff <= result;
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.cursor_column   = rsp_ff.cursor_column;
   assign rsp_if.cursor_row      = rsp_ff.cursor_row;
   assign rsp_if.cursor_position = rsp_ff.cursor_position;
   assign rsp_if.bell            = rsp_ff.bell;
   assign rsp_if.cell_character  = rsp_ff.cell_character;
   assign rsp_if.cell_attribute  = rsp_ff.cell_attribute;

endmodule

`default_nettype wire

FILE: bench/tcce_console_scoreboard_pkg.sv
// scoreboard of the text console bench: tracks screen cells, cursor and attribute
// and queues the cursor and cell read-back that each command transaction should produce
// depends on tcce_pkg for widths, codes and the item and result structs

package tcce_console_scoreboard_pkg;

   import tcce_pkg::*;

   class console_scoreboard;

      // shadow of the screen and cursor
      logic [CELL_W-1:0] cells [CELL_COUNT];
      int unsigned       col;
      int unsigned       row;

      // attribute registers
      logic              blink;
      logic [2:0]        background;
      logic [3:0]        foreground;

      result_type        results_due [$];

      int unsigned       errors;
      int unsigned       checked;
      int unsigned       scrolls;
      int unsigned       clears;
      int unsigned       reads;
      int unsigned       bells;

      function new();
         col        = 0;
         row        = 0;
         blink      = 1'b0;
         background = '0;
         foreground = '0;
         errors     = 0;
         checked    = 0;
         scrolls    = 0;
         clears     = 0;
         reads      = 0;
         bells      = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            REG_BLINK_ENABLE:     blink      = data[0];
            REG_BACKGROUND_COLOR: background = data[2:0];
            REG_FOREGROUND_COLOR: foreground = data[3:0];
            default: ;
         endcase
      endfunction

      function logic [ATTR_W-1:0] attribute();
         return {blink, background, foreground};
      endfunction

      // one row down, scrolling the screen up at the bottom
      function void line_down();
         row++;
         if (row >= LINES) begin
            for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
               cells[i] = cells[i + COLUMNS];
            for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
               cells[i] = {attribute(), BLANK_CHAR};
            row = LINES - 1;
            scrolls++;
         end
      endfunction

      function void new_line();
         col = 0;
         line_down();
      endfunction

      // returns the bell flag
      function logic put_byte(logic [CHAR_W-1:0] c);
         case (c)
            CH_BELL: return 1'b1;
            CH_BACKSPACE: begin
               if (col > 0)
                  col--;
            end
            CH_TAB: begin
               if ((col + 1) % TAB_STOP == 0)
                  col++;
               col -= col % TAB_STOP;
               col += TAB_STOP;
               if (col >= COLUMNS)
                  new_line();
            end
            CH_NEWLINE: new_line();
            CH_VTAB, CH_FORMFEED: line_down();
            CH_RETURN: col = 0;
            default: begin
               cells[row * COLUMNS + col] = {attribute(), c};
               col++;
               if (col >= COLUMNS)
                  new_line();
            end
         endcase
         return 1'b0;
      endfunction

      function void note_command(item_type it);
         result_type r;
         r = '0;
         case (it.command)
            CMD_PUT: begin
               r.bell = put_byte(it.character);
               bells += r.bell;
            end
            CMD_CLEAR: begin
               for (int i = 0; i < CELL_COUNT; i++)
                  cells[i] = {attribute(), BLANK_CHAR};
               col = 0;
               row = 0;
               clears++;
            end
            CMD_READ: begin
               if (it.cell_index < CELL_COUNT)
                  {r.cell_attribute, r.cell_character} = cells[it.cell_index];
               reads++;
            end
            default: ;
         endcase
         r.cursor_column   = COL_W'(col);
         r.cursor_row      = ROW_W'(row);
         r.cursor_position = POS_W'(row * COLUMNS + col);
         results_due.push_back(r);
      endfunction

      function void compare_field(string field, logic [15:0] want, logic [15:0] got,
                                  realtime stamp);
         if (got !== want) begin
            errors++;
            $display("%0.1f ns: %s mismatch, expected %0d, actual %0d",
                     stamp, field, want, got);
         end
      endfunction

      function void check_response(result_type got, realtime stamp);
         result_type want;
         if (results_due.size() == 0) begin
            errors++;
            $display("%0.1f ns: response with nothing outstanding, actual %p", stamp, got);
            return;
         end
         want = results_due.pop_front();
         checked++;
         compare_field("cursor_column", want.cursor_column, got.cursor_column, stamp);
         compare_field("cursor_row", want.cursor_row, got.cursor_row, stamp);
         compare_field("cursor_position", want.cursor_position, got.cursor_position, stamp);
         compare_field("bell", want.bell, got.bell, stamp);
         compare_field("cell_character", want.cell_character, got.cell_character, stamp);
         compare_field("cell_attribute", want.cell_attribute, got.cell_attribute, stamp);
      endfunction

   endclass

endpackage

FILE: bench/tb_text_console_character_engine_unit.sv
// top level bench of the text console character engine: clock, reset, stimulus and checking
// depends on tcce_pkg, tcce_intf, tcce_console_scoreboard_pkg and the engine rtl

module tb_text_console_character_engine_unit;

   timeunit 1ns;
   timeprecision 1ps;

   import tcce_pkg::*;
   import tcce_console_scoreboard_pkg::*;

   // command code the block leaves unused
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam int ITEM_TOTAL    = 1900;
   localparam int SEGMENTS      = 6;
   localparam int PRESSURE_HOLD = 400;
   localparam int DRAIN_CYCLES  = 50;
   // worst case: every transaction a full-screen sweep plus stalls, taken well over the item count
   localparam longint LIMIT_CYCLES = 20_000_000;

   logic clock;
   logic reset;

   tcce_req_if req_bus ();
   tcce_rsp_if rsp_bus ();
   tcce_csr_if csr_bus ();

   console_scoreboard sb = new();

   // idling odds in percent, and a long receiver hold-off counted down by the receiver
   int unsigned req_idle_pct;
   int unsigned rsp_idle_pct;
   int unsigned rsp_hold_cycles;
   longint      cycle_count;

   text_console_character_engine_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: ends a hung run
   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_text_console_character_engine_unit failed");
      $finish;
   end

   // response side: check every accepted transaction, then decide ready for the next edge
   initial begin
      result_type got;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got.cursor_column   = rsp_bus.cursor_column;
            got.cursor_row      = rsp_bus.cursor_row;
            got.cursor_position = rsp_bus.cursor_position;
            got.bell            = rsp_bus.bell;
            got.cell_character  = rsp_bus.cell_character;
            got.cell_attribute  = rsp_bus.cell_attribute;
            sb.check_response(got, $realtime);
         end
         // long hold-off takes priority over the random stalls
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   function automatic item_type make_item(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                                          logic [IDX_W-1:0] idx);
      item_type it;
      it.command    = cmd;
      it.character  = ch;
      it.cell_index = idx;
      return it;
   endfunction

   // random command mix: mostly printing, a share of control bytes, reads on the cursor row
   // or anywhere on the screen and some past it, the odd clear and unused command
   function automatic item_type random_command();
      item_type    it;
      int unsigned pick;
      int unsigned sub;
      it.command    = CMD_PUT;
      it.character  = CHAR_W'($urandom_range(255));
      it.cell_index = IDX_W'($urandom_range(2047));
      pick = $urandom_range(999);
      if (pick < 5) begin
         it.command = CMD_CLEAR;
      end else if (pick < 15) begin
         it.command = CMD_UNUSED;
      end else if (pick < 105) begin
         it.command = CMD_READ;
         sub = $urandom_range(19);
         if (sub == 0)
            it.cell_index = IDX_W'($urandom_range(2047, CELL_COUNT));
         else if (sub < 10)
            it.cell_index = IDX_W'(sb.row * COLUMNS + $urandom_range(COLUMNS - 1));
         else
            it.cell_index = IDX_W'($urandom_range(CELL_COUNT - 1));
      end else if (pick < 225) begin
         it.character = CHAR_W'($urandom_range(CH_RETURN, CH_BELL));
      end
      return it;
   endfunction

   // offer one request transaction, idling first at random; valid stays high
   // when no idle falls between transactions
   task automatic send_command(input item_type it);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.command    <= it.command;
      req_bus.character  <= it.character;
      req_bus.cell_index <= it.cell_index;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_command(it);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      sb.set_register(index, data);
   endtask

   // all three attribute registers back to back; only called with nothing in flight
   task automatic set_attribute(input logic blink, input logic [2:0] background,
                                input logic [3:0] foreground);
      write_register(REG_BLINK_ENABLE, {3'b000, blink});
      write_register(REG_BACKGROUND_COLOR, {1'b0, background});
      write_register(REG_FOREGROUND_COLOR, foreground);
      csr_bus.valid <= 1'b0;
   endtask

   // sender stops and waits for every outstanding response
   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      while (sb.results_due.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      item_type    directed [$];
      int unsigned seg;
      int unsigned n;

      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.command    = CMD_PUT;
      req_bus.character  = '0;
      req_bus.cell_index = '0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = REG_BLINK_ENABLE;
      csr_bus.data       = '0;
      req_idle_pct       = 0;
      rsp_idle_pct       = 0;
      rsp_hold_cycles    = 0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed part, full attribute; the clear comes first so that no read
      // ever touches a cell that was never written
      set_attribute(1'b1, 3'd7, 4'd15);
      directed.push_back(make_item(CMD_CLEAR, 8'h00, '0));
      directed.push_back(make_item(CMD_READ, 8'hFF, '0));
      directed.push_back(make_item(CMD_PUT, 8'h41, 11'h7FF));
      directed.push_back(make_item(CMD_PUT, 8'h00, '0));         // zero byte prints
      directed.push_back(make_item(CMD_PUT, 8'hFF, '0));
      directed.push_back(make_item(CMD_PUT, CH_BELL, '0));
      directed.push_back(make_item(CMD_PUT, CH_BACKSPACE, '0));
      directed.push_back(make_item(CMD_PUT, CH_RETURN, '0));
      directed.push_back(make_item(CMD_PUT, CH_BACKSPACE, '0));  // backspace at column zero
      directed.push_back(make_item(CMD_PUT, CH_TAB, '0));
      directed.push_back(make_item(CMD_PUT, CH_BACKSPACE, '0));  // to the column before a stop
      directed.push_back(make_item(CMD_PUT, CH_TAB, '0));        // tab skips an extra stop
      directed.push_back(make_item(CMD_PUT, CH_NEWLINE, '0));
      directed.push_back(make_item(CMD_PUT, CH_VTAB, '0));
      directed.push_back(make_item(CMD_PUT, CH_FORMFEED, '0));
      directed.push_back(make_item(CMD_READ, '0, IDX_W'(CELL_COUNT - 1)));
      directed.push_back(make_item(CMD_READ, '0, IDX_W'(CELL_COUNT)));  // past the screen
      directed.push_back(make_item(CMD_READ, '0, 11'h7FF));
      directed.push_back(make_item(CMD_UNUSED, 8'hFF, 11'h7FF));
      directed.push_back(make_item(CMD_READ, '0, 11'd0));
      directed.push_back(make_item(CMD_READ, '0, 11'd1));
      directed.push_back(make_item(CMD_READ, '0, 11'd2));
      foreach (directed[i])
         send_command(directed[i]);
      drain_responses();

      // random part in segments; attribute changes only between them, with the block idle
      for (seg = 0; seg < SEGMENTS; seg++) begin
         case (seg)
            0: set_attribute(1'b0, 3'd0, 4'd0);
            2: set_attribute(1'b1, 3'd7, 4'd15);
            default: set_attribute(1'($urandom_range(1)), 3'($urandom_range(7)),
                                   4'($urandom_range(15)));
         endcase
         // receiver-heavy idling, then sender-heavy, then none
         if (seg < 2) begin
            req_idle_pct = 33;
            rsp_idle_pct = 53;
         end else if (seg < 4) begin
            req_idle_pct = 53;
            rsp_idle_pct = 33;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         for (n = 0; n < ITEM_TOTAL / SEGMENTS; n++) begin
            // long receiver hold-off while requests keep coming, so the block backs up
            if (seg == 1 && n == 100)
               rsp_hold_cycles = PRESSURE_HOLD;
            send_command(random_command());
         end
         drain_responses();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d checked responses: %0d reads, %0d clears, %0d scrolls, %0d bells",
               sb.checked, sb.reads, sb.clears, sb.scrolls, sb.bells);
      $display("attribute extremes and random settings under three idling profiles");
      if (sb.errors == 0 && sb.results_due.size() == 0) begin
         $display("tb_text_console_character_engine_unit passed");
      end else begin
         $display("tb_text_console_character_engine_unit failed");
      end
      $finish;
   end

endmodule
